@@ rtl/mesi_lru_cache_controller_assert.svh @@
`ifndef MESI_LRU_CACHE_CONTROLLER_ASSERT_SVH
`define MESI_LRU_CACHE_CONTROLLER_ASSERT_SVH
// implication checked every edge outside reset
`define MLC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
// consequence in the next cycle
`define MLC_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`endif

@@ rtl/mlc_pkg.sv @@
package mlc_pkg;
  localparam logic [2:0] REQ_READ = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_SNP_READ = 3'd2;
  localparam logic [2:0] REQ_SNP_INV = 3'd3;
  localparam logic [2:0] REQ_SNP_PROMOTE = 3'd4;
  localparam logic [2:0] OUT_HIT = 3'd0;
  localparam logic [2:0] OUT_FILL = 3'd1;
  localparam logic [2:0] OUT_STALL = 3'd2;
  localparam logic [2:0] OUT_RETRY = 3'd3;
  localparam logic [2:0] OUT_SNOOP = 3'd4;
  localparam logic [1:0] BUS_NONE = 2'd0;
  localparam logic [1:0] BUS_UPGRADE = 2'd1;
  localparam logic [1:0] BUS_READ = 2'd2;
  localparam logic [1:0] BUS_WB = 2'd3;
  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;
  localparam logic [1:0] CFG_SET_BITS = 2'd0;
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS = 2'd2;
  localparam logic [9:0] MEM_CYCLES = 10'd100;
endpackage

@@ rtl/mlc_ram.sv @@
module mlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/mesi_lru_cache_controller.sv @@
// channel    dir  tdata / payload (low bit up)
// s_axis     in   req_type[2:0] address[34:3] bus_busy[35] bus_response[37:36]
// m_axis     out  outcome, bus_action, line_state, halt, hold, victim_valid,
//                 victim_address, victim_was_shared, snoop_hit, snoop_flush
// cfg        in   cfg_index[1:0], cfg_data[3:0]
// each item goes through set read from the set memories, lookup, write-back
// a result sits in the output register; the next item enters once it is taken
// reset clears control; a clearing pass over all 2**MAX_SET_BITS sets follows,
// during which no item is accepted (configuration is taken as ever)
module mesi_lru_cache_controller
  import mlc_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // req_type, address, bus_busy, bus_response
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // see head table, outcome in the lowest bits
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  localparam int SETS = 1 << MAX_SET_BITS;
  localparam int SB = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RW = RB + 1;  // rank, can hold WAYS
  localparam int SW = WAYS * (2 + 1 + RW);
  localparam int TW = WAYS * 32;

  typedef enum logic [1:0] {CLEAR, IDLE, LOOK, DONE} fsm_t;
  fsm_t fsm;

  logic [2:0] set_bits;
  logic [3:0] off_bits, ways_cfg;
  logic [SB:0] clr_cnt;

  logic [2:0] rq_type;
  logic [31:0] rq_addr;
  logic rq_busy;
  logic [1:0] rq_resp;

  logic st_we, tg_we;
  logic [SB-1:0] st_waddr, raddr;
  logic [SW-1:0] st_wdata, st_rdata;
  logic [TW-1:0] tg_wdata, tg_rdata;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (fsm == IDLE) && !m_axis_tvalid;

  // effective configuration
  logic [3:0] s_eff, b_eff;
  logic [4:0] e_eff;
  logic [4:0] tag_sh;
  always_comb begin
    s_eff = (32'(set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, set_bits};
    b_eff = (off_bits < 4'd2) ? 4'd2 : ((off_bits > 4'd10) ? 4'd10 : off_bits);
    e_eff = (ways_cfg == 4'd0) ? 5'd1 :
            ((32'(ways_cfg) > WAYS) ? 5'(WAYS) : {1'b0, ways_cfg});
    // tag shift can reach 16
    tag_sh = {1'b0, s_eff} + {1'b0, b_eff};
  end

  function automatic logic [SB-1:0] set_of(input logic [31:0] a, input logic [3:0] s,
                                           input logic [3:0] b);
    logic [31:0] m;
    m = ((32'd1 << s) - 32'd1);
    return SB'((a >> b) & m);
  endfunction

  assign raddr = (fsm == CLEAR) ? clr_cnt[SB-1:0] :
                 set_of(s_axis_tdata[34:3], s_eff, b_eff);

  mlc_ram #(.WIDTH(SW), .DEPTH(SETS)) u_state (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(raddr), .rdata(st_rdata));
  mlc_ram #(.WIDTH(TW), .DEPTH(SETS)) u_tags (
    .clk(clk), .we(tg_we), .waddr(st_waddr), .wdata(tg_wdata),
    .raddr(raddr), .rdata(tg_rdata));

  // lookup and update logic
  logic [1:0] cst [WAYS];
  logic calc [WAYS];
  logic [RW-1:0] crk [WAYS];
  logic [31:0] ctg [WAYS];
  logic [1:0] nst [WAYS];
  logic nal [WAYS];
  logic [RW-1:0] nrk [WAYS];
  logic [31:0] ntg [WAYS];
  logic [SB-1:0] cset;
  logic [31:0] tag;
  logic [2:0] r_out;
  logic [1:0] r_bus, r_ls;
  logic [9:0] r_halt, r_hold;
  logic r_vv, r_vs, r_sh, r_sf;
  logic [31:0] r_va;
  logic wr_any;

  always_comb begin
    logic hv, ha, found, fr, isfull;
    logic [RB-1:0] hw, hwa, lw, fw, w;
    logic [RW-1:0] best, old;
    logic [4:0] n;
    logic [9:0] xfer;
    logic [1:0] resp, newst;
    for (int i = 0; i < WAYS; i++) begin
      cst[i] = st_rdata[i*(3+RW) +: 2];
      calc[i] = st_rdata[i*(3+RW) + 2];
      crk[i] = st_rdata[i*(3+RW) + 3 +: RW];
      ctg[i] = tg_rdata[i*32 +: 32];
      nst[i] = cst[i]; nal[i] = calc[i]; nrk[i] = crk[i]; ntg[i] = ctg[i];
    end
    cset = set_of(rq_addr, s_eff, b_eff);
    tag = rq_addr >> tag_sh;
    xfer = 10'((32'd2 << b_eff) >> 2);
    resp = (rq_resp == 2'd3) ? 2'd2 : rq_resp;
    hv = 1'b0; ha = 1'b0; hw = '0; hwa = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (calc[i] && ctg[i] == tag) begin
        ha = 1'b1; hwa = RB'(i);
        if (cst[i] != ST_I) begin hv = 1'b1; hw = RB'(i); end
      end
    end
    n = '0; found = 1'b0; best = '0; lw = '0; fr = 1'b0; fw = '0;
    for (int i = 0; i < WAYS; i++) begin
      n = n + 5'(calc[i]);
      if (calc[i] && (!found || crk[i] > best)) begin
        found = 1'b1; best = crk[i]; lw = RB'(i);
      end
    end
    for (int i = WAYS - 1; i >= 0; i--)
      if (!calc[i]) begin fr = 1'b1; fw = RB'(i); end
    isfull = (n >= e_eff);
    r_out = OUT_SNOOP; r_bus = BUS_NONE; r_ls = ST_I; r_halt = '0; r_hold = '0;
    r_vv = 1'b0; r_va = '0; r_vs = 1'b0; r_sh = 1'b0; r_sf = 1'b0;
    wr_any = 1'b0; w = '0; old = '0; newst = ST_I;
    if (rq_type >= REQ_SNP_READ) begin
      if (rq_type <= REQ_SNP_PROMOTE && hv) begin
        r_sh = 1'b1; wr_any = 1'b1;
        case (rq_type)
          REQ_SNP_READ: begin r_sf = (cst[hw] == ST_M); nst[hw] = ST_S; end
          REQ_SNP_INV: begin r_sf = (cst[hw] == ST_M); nst[hw] = ST_I; end
          default: if (cst[hw] == ST_S) nst[hw] = ST_E;
        endcase
        r_ls = nst[hw];
      end
    end else if (hv) begin
      if (rq_type == REQ_WRITE && cst[hw] == ST_S && rq_busy) begin
        r_out = OUT_STALL; r_ls = ST_S;
      end else begin
        wr_any = 1'b1;
        if (rq_type == REQ_WRITE) begin
          if (cst[hw] == ST_S) r_bus = BUS_UPGRADE;
          nst[hw] = ST_M;
        end
        old = crk[hw];
        for (int i = 0; i < WAYS; i++)
          if (calc[i] && crk[i] < old) nrk[i] = crk[i] + RW'(1);
        nrk[hw] = '0;
        r_out = OUT_HIT; r_ls = nst[hw];
      end
    end else if (rq_busy) begin
      r_out = OUT_STALL;
    end else begin
      wr_any = 1'b1;
      if (isfull && cst[lw] != ST_I) begin
        r_vv = 1'b1;
        r_va = (ctg[lw] << tag_sh) | (32'(cset) << b_eff);
        nst[lw] = ST_I;
        r_vs = (cst[lw] == ST_S);
      end
      if (isfull && cst[lw] == ST_M) begin
        r_out = OUT_RETRY; r_bus = BUS_WB; r_halt = MEM_CYCLES; r_hold = MEM_CYCLES;
      end else begin
        if (rq_type == REQ_READ) begin
          case (resp)
            2'd0: begin newst = ST_E; r_halt = MEM_CYCLES; r_hold = MEM_CYCLES; end
            2'd1: begin newst = ST_S; r_halt = xfer; r_hold = xfer; end
            default: begin newst = ST_S; r_halt = xfer; r_hold = xfer + MEM_CYCLES; end
          endcase
        end else begin
          newst = ST_M;
          r_halt = (resp == 2'd2) ? 10'd200 : MEM_CYCLES;
          r_hold = (resp == 2'd2) ? MEM_CYCLES : 10'd0;
        end
        if (ha) begin
          w = hwa; old = crk[hwa];
        end else if (isfull || !fr) begin
          w = lw; old = crk[lw]; ntg[lw] = tag;
        end else begin
          w = fw; old = RW'(WAYS); nal[fw] = 1'b1; ntg[fw] = tag;
        end
        for (int i = 0; i < WAYS; i++)
          if (calc[i] && crk[i] < old) nrk[i] = crk[i] + RW'(1);
        nrk[w] = '0;
        nst[w] = newst;
        r_out = OUT_FILL; r_bus = BUS_READ; r_ls = newst;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      st_wdata[i*(3+RW) +: 2] = (fsm == CLEAR) ? ST_I : nst[i];
      st_wdata[i*(3+RW) + 2] = (fsm == CLEAR) ? 1'b0 : nal[i];
      st_wdata[i*(3+RW) + 3 +: RW] = (fsm == CLEAR) ? '0 : nrk[i];
      tg_wdata[i*32 +: 32] = ntg[i];
    end
    st_we = (fsm == CLEAR) || (fsm == LOOK && wr_any);
    tg_we = (fsm == LOOK && wr_any);
    st_waddr = (fsm == CLEAR) ? clr_cnt[SB-1:0] : cset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= CLEAR;
      clr_cnt <= '0;
      m_axis_tvalid <= 1'b0;
      set_bits <= 3'd6;
      off_bits <= 4'd6;
      ways_cfg <= 4'd8;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SET_BITS: set_bits <= cfg_data[2:0];
          CFG_OFFSET_BITS: off_bits <= cfg_data;
          CFG_WAYS: ways_cfg <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (fsm)
        CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == SETS - 1) fsm <= IDLE;
        end
        IDLE: if (s_axis_tvalid && s_axis_tready) begin
          rq_type <= s_axis_tdata[2:0];
          rq_addr <= s_axis_tdata[34:3];
          rq_busy <= s_axis_tdata[35];
          rq_resp <= s_axis_tdata[37:36];
          fsm <= LOOK;
        end
        LOOK: begin
          m_axis_tdata <= {1'b0, r_sf, r_sh, r_vs, r_va, r_vv, r_hold, r_halt, r_ls,
                           r_bus, r_out};
          m_axis_tvalid <= 1'b1;
          fsm <= DONE;
        end
        DONE: fsm <= IDLE;  // lets the write-back settle before the next read
        default: fsm <= IDLE;
      endcase
    end
  end

  `include "mesi_lru_cache_controller_assert.svh"
  `MLC_ASSERT_IMP(a_no_accept_busy, fsm != IDLE, !s_axis_tready)
  `MLC_ASSERT_NXT(a_look_gives_result, fsm == LOOK, m_axis_tvalid)
  `MLC_ASSERT_IMP(a_clear_writes, fsm == CLEAR, st_we && !tg_we)
endmodule

@@ tb/mlc_checker.sv @@
`timescale 1ns / 1ps

module mlc_checker
  import mlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          req_count,
  output int          evict_count,
  output int          hit_count
);
  localparam int NSETS = 64;
  localparam int NWAYS = 8;

  // highest field first, so outcome lands in the lowest bits
  typedef struct packed {
    logic        snoop_flush;
    logic        snoop_hit;
    logic        victim_was_shared;
    logic [31:0] victim_address;
    logic        victim_valid;
    logic [9:0]  hold;
    logic [9:0]  halt;
    logic [1:0]  line_state;
    logic [1:0]  bus_action;
    logic [2:0]  outcome;
  } access_result_t;

  logic [31:0] tag_mem   [NSETS][NWAYS];
  logic [1:0]  state_mem [NSETS][NWAYS];
  logic        alloc_mem [NSETS][NWAYS];
  int          rank_mem  [NSETS][NWAYS];
  logic [2:0]  set_bits_reg;
  logic [3:0]  offset_bits_reg;
  logic [3:0]  ways_reg;
  access_result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic void promote_mru(int set, int w, int old_rank);
    for (int i = 0; i < NWAYS; i++)
      if (i != w && alloc_mem[set][i] && rank_mem[set][i] < old_rank)
        rank_mem[set][i]++;
    rank_mem[set][w] = 0;
  endfunction

  function automatic int lookup_way(int set, logic [31:0] tag, bit need_valid);
    for (int i = 0; i < NWAYS; i++)
      if (alloc_mem[set][i] && tag_mem[set][i] == tag &&
          (!need_valid || state_mem[set][i] != ST_I))
        return i;
    return -1;
  endfunction

  function automatic int oldest_way(int set);
    int best;
    int best_rank;
    bit found;
    best = 0;
    best_rank = 0;
    found = 1'b0;
    for (int i = 0; i < NWAYS; i++)
      if (alloc_mem[set][i] && (!found || rank_mem[set][i] > best_rank)) begin
        best = i;
        best_rank = rank_mem[set][i];
        found = 1'b1;
      end
    return best;
  endfunction

  function automatic access_result_t cache_access(logic [2:0] kind, logic [31:0] addr,
                                                  logic busy, logic [1:0] resp_in);
    access_result_t r;
    int sb, ob, assoc, set, hw, n, v, w;
    logic [31:0] tag, xfer;
    logic [1:0] resp, vs, newst;
    logic [9:0] halt, hold;
    r = '0;
    sb = (set_bits_reg > 6) ? 6 : set_bits_reg;
    ob = (offset_bits_reg < 2) ? 2 : ((offset_bits_reg > 10) ? 10 : offset_bits_reg);
    assoc = (ways_reg < 1) ? 1 : ((ways_reg > NWAYS) ? NWAYS : ways_reg);
    xfer = (32'd1 << ob) / 2;
    set = (addr >> ob) & ((1 << sb) - 1);
    tag = addr >> (sb + ob);
    resp = (resp_in == 2'd3) ? 2'd2 : resp_in;
    hw = lookup_way(set, tag, 1'b1);

    if (kind >= REQ_SNP_READ) begin
      r.outcome = OUT_SNOOP;
      if (kind > REQ_SNP_PROMOTE || hw < 0) return r;
      r.snoop_hit = 1'b1;
      if (kind == REQ_SNP_READ) begin
        r.snoop_flush = (state_mem[set][hw] == ST_M);
        state_mem[set][hw] = ST_S;
      end else if (kind == REQ_SNP_INV) begin
        r.snoop_flush = (state_mem[set][hw] == ST_M);
        state_mem[set][hw] = ST_I;
      end else if (state_mem[set][hw] == ST_S) begin
        state_mem[set][hw] = ST_E;
      end
      r.line_state = state_mem[set][hw];
      return r;
    end

    if (hw >= 0) begin
      if (kind == REQ_WRITE) begin
        if (state_mem[set][hw] == ST_S) begin
          if (busy) begin
            r.outcome = OUT_STALL;
            r.line_state = ST_S;
            return r;
          end
          r.bus_action = BUS_UPGRADE;
        end
        state_mem[set][hw] = ST_M;
      end
      promote_mru(set, hw, rank_mem[set][hw]);
      r.outcome = OUT_HIT;
      r.line_state = state_mem[set][hw];
      return r;
    end

    if (busy) begin
      r.outcome = OUT_STALL;
      return r;
    end

    n = 0;
    for (int i = 0; i < NWAYS; i++) n += alloc_mem[set][i];

    if (n >= assoc) begin
      v = oldest_way(set);
      vs = state_mem[set][v];
      if (vs != ST_I) begin
        r.victim_valid = 1'b1;
        r.victim_address = (tag_mem[set][v] << (sb + ob)) | (32'(set) << ob);
        state_mem[set][v] = ST_I;
        if (vs == ST_M) begin
          r.outcome = OUT_RETRY;
          r.bus_action = BUS_WB;
          r.halt = MEM_CYCLES;
          r.hold = MEM_CYCLES;
          return r;
        end
        r.victim_was_shared = (vs == ST_S);
      end
    end

    if (kind == REQ_READ) begin
      if (resp == 2'd0) begin
        newst = ST_E; halt = MEM_CYCLES; hold = MEM_CYCLES;
      end else if (resp == 2'd1) begin
        newst = ST_S; halt = xfer[9:0]; hold = xfer[9:0];
      end else begin
        newst = ST_S; halt = xfer[9:0]; hold = xfer[9:0] + MEM_CYCLES;
      end
    end else begin
      newst = ST_M;
      if (resp == 2'd2) begin
        hold = MEM_CYCLES; halt = 10'd200;
      end else begin
        hold = 10'd0; halt = MEM_CYCLES;
      end
    end

    hw = lookup_way(set, tag, 1'b0);
    if (hw >= 0) begin
      w = hw;
      promote_mru(set, w, rank_mem[set][w]);
    end else if (n >= assoc) begin
      w = oldest_way(set);
      tag_mem[set][w] = tag;
      promote_mru(set, w, rank_mem[set][w]);
    end else begin
      w = 0;
      for (int i = NWAYS - 1; i >= 0; i--)
        if (!alloc_mem[set][i]) w = i;
      alloc_mem[set][w] = 1'b1;
      tag_mem[set][w] = tag;
      promote_mru(set, w, NWAYS);
    end
    state_mem[set][w] = newst;
    r.outcome = OUT_FILL;
    r.bus_action = BUS_READ;
    r.line_state = newst;
    r.halt = halt;
    r.hold = hold;
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t want, got;
    if (rst) begin
      for (int s = 0; s < NSETS; s++)
        for (int w = 0; w < NWAYS; w++) begin
          state_mem[s][w] = ST_I;
          alloc_mem[s][w] = 1'b0;
          rank_mem[s][w] = 0;
        end
      set_bits_reg = 3'd6;
      offset_bits_reg = 4'd6;
      ways_reg = 4'd8;
      expected_q.delete();
      fail_count = 0;
      req_count = 0;
      evict_count = 0;
      hit_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS:    set_bits_reg = cfg_data[2:0];
          CFG_OFFSET_BITS: offset_bits_reg = cfg_data;
          CFG_WAYS:        ways_reg = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[62:0];
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.outcome != want.outcome) begin
            $error("outcome: expected %0d got %0d", want.outcome, got.outcome); fail_count++;
          end
          if (got.bus_action != want.bus_action) begin
            $error("bus_action: expected %0d got %0d", want.bus_action, got.bus_action);
            fail_count++;
          end
          if (got.line_state != want.line_state) begin
            $error("line_state: expected %0d got %0d", want.line_state, got.line_state);
            fail_count++;
          end
          if (got.halt != want.halt) begin
            $error("halt_cycles: expected %0d got %0d", want.halt, got.halt); fail_count++;
          end
          if (got.hold != want.hold) begin
            $error("bus_hold_cycles: expected %0d got %0d", want.hold, got.hold);
            fail_count++;
          end
          if (got.victim_valid != want.victim_valid) begin
            $error("victim_valid: expected %0d got %0d", want.victim_valid,
                   got.victim_valid);
            fail_count++;
          end
          if (got.victim_address != want.victim_address) begin
            $error("victim_address: expected %h got %h", want.victim_address,
                   got.victim_address);
            fail_count++;
          end
          if (got.victim_was_shared != want.victim_was_shared) begin
            $error("victim_was_shared: expected %0d got %0d", want.victim_was_shared,
                   got.victim_was_shared);
            fail_count++;
          end
          if (got.snoop_hit != want.snoop_hit) begin
            $error("snoop_hit: expected %0d got %0d", want.snoop_hit, got.snoop_hit);
            fail_count++;
          end
          if (got.snoop_flush != want.snoop_flush) begin
            $error("snoop_flush: expected %0d got %0d", want.snoop_flush, got.snoop_flush);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = cache_access(s_axis_tdata[2:0], s_axis_tdata[34:3], s_axis_tdata[35],
                            s_axis_tdata[37:36]);
        expected_q.push_back(want);
        req_count++;
        if (want.victim_valid) evict_count++;
        if (want.outcome == OUT_HIT) hit_count++;
      end
    end
  end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import mlc_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // req_type, address, bus_busy, bus_response
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [63:0] m_axis_tdata;       // outcome .. snoop_flush, see checker struct
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  int fail_count, pending, req_count, evict_count, hit_count;
  int send_idle = 0;   // percent of cycles the sender holds back
  int recv_stall = 0;  // percent of cycles the receiver stalls
  bit pressure_go = 0;
  bit pressure_done = 0;
  int pressure_left = 0;
  int quiet_cycles = 0;
  int cur_s = 6, cur_b = 6;
  logic [31:0] addr_pool[16];

  always #5 clk = ~clk;

  mesi_lru_cache_controller dut (.*);

  mlc_checker u_checker (.*);

  // receiver, with one long hold-off so the input backs up
  always @(posedge clk) begin
    if (pressure_go && !pressure_done) begin
      pressure_left <= 400;
      pressure_done <= 1;
      m_axis_tready <= 0;
    end else if (pressure_left > 1) begin
      pressure_left <= pressure_left - 1;
      m_axis_tready <= 0;
    end else begin
      pressure_left <= 0;
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_req(logic [2:0] kind, logic [31:0] addr, logic busy,
                          logic [1:0] resp);
    if ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b00, resp, busy, addr, kind};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  task automatic write_config(logic [3:0] sbits, logic [3:0] obits, logic [3:0] ways);
    logic [3:0] vals[3];
    logic [1:0] idx[3];
    vals = '{sbits, obits, ways};
    idx = '{CFG_SET_BITS, CFG_OFFSET_BITS, CFG_WAYS};
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(negedge clk); while (!cfg_ready);
      @(posedge clk);
    end
    cfg_valid <= 0;
    cur_s = (sbits[2:0] > 6) ? 6 : sbits[2:0];
    cur_b = (obits < 2) ? 2 : ((obits > 10) ? 10 : obits);
    // addresses crowd into at most two sets so that evictions are common
    for (int k = 0; k < 16; k++)
      addr_pool[k] = ($urandom << (cur_s + cur_b)) |
                     (32'($urandom_range(0, 1)) << cur_b);
  endtask

  task automatic random_reqs(int count);
    logic [2:0] kind;
    logic [31:0] addr;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = REQ_READ;
      else if (pick < 72) kind = REQ_WRITE;
      else if (pick < 95) kind = 3'($urandom_range(REQ_SNP_READ, REQ_SNP_PROMOTE));
      else kind = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 99) < 85)
        addr = addr_pool[$urandom_range(0, 15)] ^ ($urandom & ((32'd1 << cur_b) - 1));
      else
        addr = $urandom;
      send_req(kind, addr, $urandom_range(0, 99) < 15, 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    write_config(4'd6, 4'd6, 4'd8);

    // directed: one line through the MESI states, then misses and odd request kinds
    send_req(REQ_READ, 32'h1234_5680, 0, 2'd0);
    send_req(REQ_READ, 32'h1234_56bf, 0, 2'd0);
    send_req(REQ_WRITE, 32'h1234_5680, 0, 2'd0);
    send_req(REQ_SNP_READ, 32'h1234_5680, 0, 2'd0);
    send_req(REQ_WRITE, 32'h1234_5680, 1, 2'd0);
    send_req(REQ_WRITE, 32'h1234_5680, 0, 2'd0);
    send_req(REQ_SNP_INV, 32'h1234_5680, 0, 2'd0);
    send_req(REQ_SNP_PROMOTE, 32'h1234_5680, 0, 2'd0);
    send_req(REQ_READ, 32'h0000_0000, 1, 2'd0);
    send_req(REQ_READ, 32'h0000_0000, 0, 2'd1);
    send_req(REQ_SNP_PROMOTE, 32'h0000_0000, 0, 2'd0);
    send_req(REQ_READ, 32'hffff_ffff, 0, 2'd2);
    send_req(REQ_READ, 32'h8000_0040, 0, 2'd3);
    send_req(REQ_WRITE, 32'h4000_0080, 0, 2'd2);
    send_req(REQ_WRITE, 32'h2000_00c0, 0, 2'd1);
    send_req(3'd5, 32'h1234_5680, 0, 2'd0);
    send_req(3'd7, 32'hffff_ffff, 1, 2'd3);
    // fill set 0 past its ways: clean victims, then a write hit on a modified line
    for (int k = 1; k <= 9; k++)
      send_req((k % 2) ? REQ_READ : REQ_WRITE, 32'(k) << 12, 0, 2'(k % 3));
    send_req(REQ_WRITE, 32'h0000_2000, 0, 2'd0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 87; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      case (ph)
        0: write_config(4'd0, 4'd2, 4'd1);
        1: write_config(4'd7, 4'd15, 4'd15);
        2: write_config(4'd0, 4'd0, 4'd0);
        3: write_config(4'd3, 4'd10, 4'd4);
        4: write_config(4'd2, 4'd4, 4'd2);
        5: write_config(4'd6, 4'd6, 4'd8);
        6: write_config(4'd1, 4'd3, 4'd3);
        default: write_config(4'd4, 4'd9, 4'd8);
      endcase
      if (ph == 4) pressure_go <= 1;
      random_reqs(60);
    end

    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d requests over 9 cache geometries, %0d hits, %0d lines evicted",
             req_count, hit_count, evict_count);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
